/* hdl/pca_pkg.sv */
// Shared types, constants and helper functions for the photon cylinder
// acceptance block. No dependencies; pca_cordic, pca_isqrt and the top level import this package.
`timescale 1ns / 1ps
`default_nettype none

package pca_pkg;

  // Datapath widths of the rotator stages (Q30 values with headroom).
  localparam int XW = 36;
  localparam int ZW = 34;

  // Square root: 50-bit radicand, one result bit per stage.
  localparam int SQ_W     = 50;
  localparam int SQ_STEPS = 25;

  localparam int GUARD     = 6;
  localparam int SINH_FRAC = 20;
  localparam int K_MAX     = 17;

  localparam logic [39:0] LN2_Q30 = 40'd744261118;
  localparam logic [39:0] ETA_CAP_Q30 = 40'd12884901888;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic signed [XW-1:0] CIRC_START_Q30 = 36'sd652032874;
  localparam logic signed [XW-1:0] HYP_START_Q30 = 36'sd1296540104;

  localparam logic [17:0] INV_SINE_MAX = 18'd262143;
  localparam logic signed [43:0] Z_MAX = 44'sd8388607;
  localparam logic signed [43:0] Z_MIN = -44'sd8388608;

  typedef enum logic [1:0] {
    CFG_OFFSET_X = 2'd0,
    CFG_OFFSET_Y = 2'd1,
    CFG_RADIUS   = 2'd2,
    CFG_Z_LIMIT  = 2'd3
  } cfg_idx_e;

  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] val;
    case (i)
      0: val = 34'sd843314856;
      1: val = 34'sd497837829;
      2: val = 34'sd263043836;
      3: val = 34'sd133525158;
      4: val = 34'sd67021686;
      5: val = 34'sd33543515;
      6: val = 34'sd16775850;
      7: val = 34'sd8388437;
      8: val = 34'sd4194282;
      9: val = 34'sd2097149;
      default: val = 34'sd1 <<< (30 - i);
    endcase
    return val;
  endfunction

  function automatic logic signed [ZW-1:0] atanh_q30(input int i);
    logic signed [ZW-1:0] val;
    case (i)
      1: val = 34'sd589812981;
      2: val = 34'sd274247418;
      3: val = 34'sd134923406;
      4: val = 34'sd67196451;
      5: val = 34'sd33565361;
      6: val = 34'sd16778582;
      7: val = 34'sd8388779;
      8: val = 34'sd4194325;
      9: val = 34'sd2097155;
      10: val = 34'sd1048576;
      default: val = 34'sd1 <<< (30 - i);
    endcase
    return val;
  endfunction

  // Shift used by hyperbolic step n; shifts 4, 13, 40, ... are used twice.
  function automatic int hyp_shift(input int n);
    int  i;
    int  rep;
    int  k;
    bit  repd;
    i    = 1;
    rep  = 4;
    repd = 1'b0;
    for (k = 0; k < n; k++) begin
      if (i == rep && !repd) begin
        repd = 1'b1;
      end else begin
        if (i == rep) begin
          rep  = 3 * rep + 1;
          repd = 1'b0;
        end
        i++;
      end
    end
    return i;
  endfunction

  // Right shift with rounding half away from zero.
  function automatic logic signed [67:0] rnd_shift(input logic signed [67:0] v, input int s);
    logic signed [67:0] mag;
    logic signed [67:0] res;
    mag = (v < 0) ? -v : v;
    res = (mag + (68'sd1 <<< (s - 1))) >>> s;
    return (v < 0) ? -res : res;
  endfunction

endpackage

`default_nettype wire

/* hdl/pca_delay.sv */
// Enable-gated delay line that carries side data alongside a pipeline.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module pca_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire              clk_i,
  input  wire              en_i,
  input  wire [WIDTH-1:0]  d_i,
  output logic [WIDTH-1:0] d_o
);

  logic [WIDTH-1:0] line_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      line_q[0] <= d_i;
      for (int n = 1; n < DEPTH; n++) begin
        line_q[n] <= line_q[n-1];
      end
    end
  end

  assign d_o = line_q[DEPTH-1];

endmodule

`default_nettype wire

/* hdl/pca_cordic.sv */
// Unrolled CORDIC rotator, one iteration per register stage, in circular or
// hyperbolic mode. Depends on pca_pkg for widths and angle tables.
`timescale 1ns / 1ps
`default_nettype none

module pca_cordic
  import pca_pkg::*;
#(
  parameter int STEPS = 16,
  parameter bit HYPER = 1'b0
) (
  input  wire                   clk_i,
  input  wire                   en_i,
  input  wire signed [XW-1:0]   x_i,
  input  wire signed [XW-1:0]   y_i,
  input  wire signed [ZW-1:0]   z_i,
  output logic signed [XW-1:0]  x_o,
  output logic signed [XW-1:0]  y_o
);

  logic signed [XW-1:0] xa [STEPS+1];
  logic signed [XW-1:0] ya [STEPS+1];
  logic signed [ZW-1:0] za [STEPS];

  assign xa[0] = x_i;
  assign ya[0] = y_i;
  assign za[0] = z_i;

  for (genvar g = 0; g < STEPS; g++) begin : g_step
    localparam int SH = HYPER ? hyp_shift(g) : g;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [XW-1:0] x_d;
    logic signed [XW-1:0] y_d;
    logic signed [ZW-1:0] z_d;
    logic signed [ZW-1:0] ang;
    logic signed [XW-1:0] x_q;
    logic signed [XW-1:0] y_q;

    always_comb begin
      dx  = xa[g] >>> SH;
      dy  = ya[g] >>> SH;
      ang = HYPER ? atanh_q30(SH) : atan_q30(SH);
      if (za[g] >= 0) begin
        x_d = HYPER ? xa[g] + dy : xa[g] - dy;
        y_d = ya[g] + dx;
        z_d = za[g] - ang;
      end else begin
        x_d = HYPER ? xa[g] - dy : xa[g] + dy;
        y_d = ya[g] - dx;
        z_d = za[g] + ang;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q <= x_d;
        y_q <= y_d;
      end
    end

    assign xa[g+1] = x_q;
    assign ya[g+1] = y_q;

    // The angle of the last stage is not needed downstream.
    if (g < STEPS - 1) begin : g_z
      logic signed [ZW-1:0] z_q;
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          z_q <= z_d;
        end
      end
      assign za[g+1] = z_q;
    end
  end

  assign x_o = xa[STEPS];
  assign y_o = ya[STEPS];

endmodule

`default_nettype wire

/* hdl/pca_isqrt.sv */
// Pipelined floor square root, one result bit per register stage.
// Depends on pca_pkg for the radicand width and stage count.
`timescale 1ns / 1ps
`default_nettype none

module pca_isqrt
  import pca_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  en_i,
  input  wire [SQ_W-1:0]       rad_i,
  output logic [SQ_STEPS-1:0]  root_o
);

  logic [SQ_W-1:0] va [SQ_STEPS];
  logic [SQ_W-1:0] ra [SQ_STEPS+1];

  assign va[0] = rad_i;
  assign ra[0] = '0;

  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_step
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_STEPS - 1 - g));
    logic [SQ_W-1:0] trial;
    logic [SQ_W-1:0] v_d;
    logic [SQ_W-1:0] r_d;
    logic [SQ_W-1:0] r_q;

    always_comb begin
      trial = ra[g] + BIT;
      if (va[g] >= trial) begin
        v_d = va[g] - trial;
        r_d = (ra[g] >> 1) + BIT;
      end else begin
        v_d = va[g];
        r_d = ra[g] >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q <= r_d;
      end
    end
    assign ra[g+1] = r_q;

    if (g < SQ_STEPS - 1) begin : g_v
      logic [SQ_W-1:0] v_q;
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          v_q <= v_d;
        end
      end
      assign va[g+1] = v_q;
    end
  end

  assign root_o = ra[SQ_STEPS][SQ_STEPS-1:0];

endmodule

`default_nettype wire

/* hdl/photon_cylinder_acceptance.sv */
// Top level of the photon cylinder acceptance pipeline.
// Depends on pca_pkg, pca_delay, pca_cordic and pca_isqrt.
//
// Usage: each transfer on the s_axis channel carries one direction (eta,
// phi_turn) and a vertex z. One result per item leaves on m_axis: the z where
// the straight line from the beam spot meets the cylinder, 1/sin(theta), and
// the flags accepted and no_crossing in tuser.
// Geometry registers (offset_x, offset_y, radius, z_limit) are written over the
// cfg channel, which is always ready; write them only while no item is in
// flight.
// The pipeline has 12 + CORDIC_STEPS + 25 register stages, a depth set by the
// two rotators that run side by side and the 25-stage square root.
// One item enters every cycle unless a result waits with m_axis_tready_i low.
// The whole pipeline advances together; while m_axis_tready_i is low with a
// result waiting, every stage holds and s_axis_tready_o drops, so nothing is
// lost or repeated.
// Reset clears the valid bits and loads the default geometry; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module photon_cylinder_acceptance
  import pca_pkg::*;
#(
  parameter int FRAC_BITS    = 12,
  parameter int CORDIC_STEPS = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [55:0] s_axis_tdata_i,   // eta[15:0], phi_turn[31:16], vertex_z[50:32]
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // crossing_z[23:0], inverse_sine[41:24]
  output logic [1:0]  m_axis_tuser_o,   // accepted[0], no_crossing[1]
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [18:0] cfg_data_i
);

  localparam int SH_IN = 30 - FRAC_BITS;
  localparam int LAT   = 12 + CORDIC_STEPS + SQ_STEPS;

  // Configuration registers.
  logic signed [15:0] offset_x_q, offset_y_q;
  logic [17:0]        radius_q;
  logic [18:0]        z_limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_x_q <= 16'sd393;
      offset_y_q <= -16'sd262;
      radius_q   <= 18'd66355;
      z_limit_q  <= 19'd102400;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_OFFSET_X: offset_x_q <= cfg_data_i[15:0];
        CFG_OFFSET_Y: offset_y_q <= cfg_data_i[15:0];
        CFG_RADIUS:   radius_q   <= cfg_data_i[17:0];
        CFG_Z_LIMIT:  z_limit_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic signed [21:0] oxg, oyg;
  logic signed [24:0] rrg;
  assign oxg = {offset_x_q, 6'b0};
  assign oyg = {offset_y_q, 6'b0};
  assign rrg = $signed({1'b0, radius_q, 6'b0});

  // Pipeline control: all stages move together.
  logic en;
  logic [LAT-1:0] valid_q;

  assign en              = !valid_q[LAT-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = valid_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[LAT-2:0], s_axis_tvalid_i};
    end
  end

  // Input register.
  logic signed [15:0] eta_0;
  logic [15:0]        phi_0;
  logic signed [18:0] vz_0;

  always_ff @(posedge clk_i) begin
    if (en) begin
      eta_0 <= s_axis_tdata_i[15:0];
      phi_0 <= s_axis_tdata_i[31:16];
      vz_0  <= s_axis_tdata_i[50:32];
    end
  end

  // Argument reduction: |eta| = k*ln2 + r, and phi to a first-quadrant angle.
  logic [16:0] eta_mag;
  logic [39:0] a_full, a_cap, base;
  logic [4:0]  k_d;
  logic [44:0] cz_prod;

  always_comb begin
    eta_mag = (eta_0 < 0) ? 17'(-$signed({eta_0[15], eta_0})) : {1'b0, eta_0};
    a_full  = 40'(eta_mag) << SH_IN;
    a_cap   = (a_full > ETA_CAP_Q30) ? ETA_CAP_Q30 : a_full;
    k_d     = '0;
    base    = '0;
    for (int j = 1; j <= K_MAX; j++) begin
      if (a_cap >= 40'(j) * LN2_Q30) begin
        k_d  = 5'(j);
        base = 40'(j) * LN2_Q30;
      end
    end
    cz_prod = phi_0[13:0] * HALF_PI_Q30;
  end

  logic [4:0]           k_1;
  logic                 neg_1;
  logic [1:0]           q_1;
  logic signed [18:0]   vz_1;
  logic signed [ZW-1:0] hz_1, cz_1;

  always_ff @(posedge clk_i) begin
    if (en) begin
      k_1   <= k_d;
      neg_1 <= eta_0 < 0;
      q_1   <= phi_0[15:14];
      vz_1  <= vz_0;
      hz_1  <= $signed(ZW'(a_cap - base));
      cz_1  <= $signed(ZW'(cz_prod >> 14));
    end
  end

  logic signed [XW-1:0] hc, hs, cx, cy;

  pca_cordic #(.STEPS(CORDIC_STEPS), .HYPER(1'b1)) u_hyp (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (HYP_START_Q30),
    .y_i   ('0),
    .z_i   (hz_1),
    .x_o   (hc),
    .y_o   (hs)
  );

  pca_cordic #(.STEPS(CORDIC_STEPS), .HYPER(1'b0)) u_circ (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (CIRC_START_Q30),
    .y_i   ('0),
    .z_i   (cz_1),
    .x_o   (cx),
    .y_o   (cy)
  );

  logic [4:0]         k_c;
  logic               neg_c;
  logic [1:0]         q_c;
  logic signed [18:0] vz_c;

  pca_delay #(.WIDTH(27), .DEPTH(CORDIC_STEPS)) u_dly_rot (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({k_1, neg_1, q_1, vz_1}),
    .d_o   ({k_c, neg_c, q_c, vz_c})
  );

  // Stage A: undo the ln2 reduction by shifting, rotate to the quadrant and
  // form the two projections of the beam offset.
  logic signed [XW:0]   ep, em;
  logic signed [31:0]   cs, sn;

  always_comb begin
    ep = (XW+1)'(hc) + (XW+1)'(hs);
    em = (XW+1)'(hc) - (XW+1)'(hs);
    case (q_c)
      2'd0:    begin cs = 32'(cx);  sn = 32'(cy);  end
      2'd1:    begin cs = 32'(-cy); sn = 32'(cx);  end
      2'd2:    begin cs = 32'(-cx); sn = 32'(-cy); end
      default: begin cs = 32'(cy);  sn = 32'(-cx); end
    endcase
  end

  logic signed [51:0] big_a;
  logic signed [XW:0] small_a;
  logic signed [53:0] prodx_a, prody_a;
  logic               neg_a;
  logic signed [18:0] vz_a;

  always_ff @(posedge clk_i) begin
    if (en) begin
      big_a   <= 52'(ep) <<< k_c;
      small_a <= em >>> k_c;
      prodx_a <= cs * oxg;
      prody_a <= sn * oyg;
      neg_a   <= neg_c;
      vz_a    <= vz_c;
    end
  end

  // Stage B: cosh and sinh of |eta|, projection sum, squares of the geometry.
  logic signed [52:0] chq_b, shq_b;
  logic signed [54:0] psum_b;
  logic signed [43:0] oxx_b, oyy_b;
  logic signed [49:0] rrr_b;
  logic               neg_b;
  logic signed [18:0] vz_b;

  always_ff @(posedge clk_i) begin
    if (en) begin
      chq_b  <= (53'(big_a) + 53'(small_a)) >>> 1;
      shq_b  <= (53'(big_a) - 53'(small_a)) >>> 1;
      psum_b <= 55'(prodx_a) + 55'(prody_a);
      oxx_b  <= oxg * oxg;
      oyy_b  <= oyg * oyg;
      rrr_b  <= 50'(rrg * rrg);
      neg_b  <= neg_a;
      vz_b   <= vz_a;
    end
  end

  // Stage C: rescale to output precision, give sinh the sign of eta, form c.
  logic signed [67:0] inv_r, sh_r, p_r;

  always_comb begin
    inv_r = rnd_shift(68'(chq_b), SH_IN);
    sh_r  = rnd_shift(68'(shq_b), 30 - SINH_FRAC);
    p_r   = rnd_shift(68'(psum_b), 30);
  end

  logic [17:0]        inv_c;
  logic signed [39:0] sh_c;
  logic signed [24:0] p_c;
  logic signed [50:0] c_c;
  logic signed [18:0] vz_c2;

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (inv_r < 0) begin
        inv_c <= '0;
      end else if (inv_r > 68'(INV_SINE_MAX)) begin
        inv_c <= INV_SINE_MAX;
      end else begin
        inv_c <= inv_r[17:0];
      end
      sh_c  <= neg_b ? -40'(sh_r) : 40'(sh_r);
      p_c   <= 25'(p_r);
      c_c   <= 51'(oxx_b) + 51'(oyy_b) - 51'(rrr_b);
      vz_c2 <= vz_b;
    end
  end

  // Stage D: p squared.
  logic signed [49:0] pp_d;
  logic signed [50:0] c_d;
  logic signed [24:0] p_d;
  logic [17:0]        inv_d;
  logic signed [39:0] sh_d;
  logic signed [18:0] vz_d;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pp_d  <= p_c * p_c;
      c_d   <= c_c;
      p_d   <= p_c;
      inv_d <= inv_c;
      sh_d  <= sh_c;
      vz_d  <= vz_c2;
    end
  end

  // Stage E: discriminant.
  logic signed [50:0] disc;
  assign disc = 51'(pp_d) - c_d;

  logic [SQ_W-1:0]    disc_e;
  logic               nocross_e;
  logic signed [24:0] p_e;
  logic [17:0]        inv_e;
  logic signed [39:0] sh_e;
  logic signed [18:0] vz_e;

  always_ff @(posedge clk_i) begin
    if (en) begin
      nocross_e <= disc < 0;
      disc_e    <= (disc < 0) ? '0 : disc[SQ_W-1:0];
      p_e       <= p_d;
      inv_e     <= inv_d;
      sh_e      <= sh_d;
      vz_e      <= vz_d;
    end
  end

  logic [SQ_STEPS-1:0] root;
  logic                nocross_s;
  logic signed [24:0]  p_s;
  logic [17:0]         inv_s;
  logic signed [39:0]  sh_s;
  logic signed [18:0]  vz_s;

  pca_isqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (disc_e),
    .root_o (root)
  );

  pca_delay #(.WIDTH(103), .DEPTH(SQ_STEPS)) u_dly_sqrt (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({nocross_e, p_e, inv_e, sh_e, vz_e}),
    .d_o   ({nocross_s, p_s, inv_s, sh_s, vz_s})
  );

  // Stage G: transverse path length.
  logic signed [26:0] t_g;
  logic               nocross_g, nocross_h, nocross_i, nocross_j;
  logic [17:0]        inv_g, inv_h, inv_i, inv_j;
  logic signed [39:0] sh_g;
  logic signed [18:0] vz_g, vz_h, vz_i, vz_j;

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_g       <= 27'(root) - 27'(p_s);
      nocross_g <= nocross_s;
      inv_g     <= inv_s;
      sh_g      <= sh_s;
      vz_g      <= vz_s;
    end
  end

  // Stage H: t * sinh split into two partial products.
  logic signed [47:0] mlo_h;
  logic signed [46:0] mhi_h;

  always_ff @(posedge clk_i) begin
    if (en) begin
      mlo_h     <= t_g * $signed({1'b0, sh_g[19:0]});
      mhi_h     <= t_g * $signed(sh_g[39:20]);
      nocross_h <= nocross_g;
      inv_h     <= inv_g;
      vz_h      <= vz_g;
    end
  end

  // Stage I: recombine the partial products.
  logic signed [67:0] prod_i;

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_i    <= (68'(mhi_h) <<< 20) + 68'(mlo_h);
      nocross_i <= nocross_h;
      inv_i     <= inv_h;
      vz_i      <= vz_h;
    end
  end

  // Stage J: back to output precision and add the vertex.
  logic signed [67:0] dz_r;
  logic signed [43:0] z_j;
  assign dz_r = rnd_shift(prod_i, GUARD + SINH_FRAC);

  always_ff @(posedge clk_i) begin
    if (en) begin
      z_j       <= 44'(vz_i) + 44'(dz_r);
      nocross_j <= nocross_i;
      inv_j     <= inv_i;
    end
  end

  // Stage K: acceptance test on the unsaturated z, then saturation.
  logic signed [43:0] z_abs;
  logic signed [23:0] z_sat;
  logic               acc;

  always_comb begin
    z_abs = (z_j < 0) ? -z_j : z_j;
    acc   = !nocross_j && (z_abs < $signed({25'b0, z_limit_q}));
    if (nocross_j) begin
      z_sat = '0;
    end else if (z_j > Z_MAX) begin
      z_sat = 24'(Z_MAX);
    end else if (z_j < Z_MIN) begin
      z_sat = 24'(Z_MIN);
    end else begin
      z_sat = z_j[23:0];
    end
  end

  logic signed [23:0] z_q;
  logic [17:0]        inv_q;
  logic               acc_q, nocross_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      z_q       <= z_sat;
      inv_q     <= inv_j;
      acc_q     <= acc;
      nocross_q <= nocross_j;
    end
  end

  assign m_axis_tdata_o = {6'b0, inv_q, z_q};
  assign m_axis_tuser_o = {nocross_q, acc_q};

endmodule

`default_nettype wire

/* hdl/pca_checker.sv */
// Port-level checks for photon_cylinder_acceptance, attached by bind.
// Depends only on the top level's port list.
`timescale 1ns / 1ps
`default_nettype none

module pca_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        s_axis_tready_o,
  input wire        m_axis_tvalid_o,
  input wire        m_axis_tready_i,
  input wire [47:0] m_axis_tdata_o,
  input wire [1:0]  m_axis_tuser_o
);

  // A result waiting for the receiver stays offered.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output valid dropped during stall");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("output payload changed during stall");

  // A line that misses the cylinder has zero z and is never accepted.
  a_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1] |-> !m_axis_tuser_o[0] && m_axis_tdata_o[23:0] == 24'd0)
    else $error("no_crossing result with accept or nonzero z");

  // A ready receiver never stalls the input.
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready_i |-> s_axis_tready_o)
    else $error("input stalled while output is ready");

endmodule

bind photon_cylinder_acceptance pca_checker u_pca_checker (.*);

`default_nettype wire
